@@ rtl/lzwvwd_pkg.sv @@
package lzwvwd_pkg;

   // fixed code layout
   localparam int MinCodeBits = 9;
   localparam int ClearCode   = 1 << (MinCodeBits - 1);
   localparam int EndCode     = ClearCode + 1;
   localparam int FirstSlot   = ClearCode + 2;

   // parameter defaults
   localparam int DefMaxCodeBits = 12;
   localparam int DefOutBurst    = 64;

   // request word modes
   typedef enum logic [1:0] {
      MODE_BYTE    = 2'd0,
      MODE_CONT    = 2'd1,
      MODE_RESTART = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   // what a freshly unpacked code does
   typedef enum logic [1:0] {
      KIND_SKIP   = 2'd0,
      KIND_SINGLE = 2'd1,
      KIND_WALK   = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CODE,
      S_WALK_RD,
      S_WALK_WR,
      S_FINISH,
      S_START,
      S_RD,
      S_LOAD,
      S_SEND
   } state_type;

   typedef struct packed {
      logic restart;
      logic take_byte;
      logic do_code;
      logic walk_rd;
      logic walk_step;
      logic finish;
      logic drain_start;
      logic buf_rd;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic     code_ready;
      logic     pending;
      logic     ended;
      kind_type kind;
      logic     walk_more;
      logic     last;
   } status_type;

endpackage

@@ rtl/lzw_variable_width_decoder.sv @@
// LZW decoder for 9 to MAX_CODE_BITS wide codes packed lsb first, one compressed byte per
// request word. Code 256 clears the dictionary, 257 ends the stream. Each code's string is
// rebuilt by walking its prefix chain, each dictionary step a registered table read
// followed by a buffer write. Each decoded byte then passes through buffer read, load
// and send on the response side, at most OUT_BURST bytes per request word; a continue
// word drains the rest. Restart needs no clearing pass.
module lzw_variable_width_decoder
   import lzwvwd_pkg::*;
#(
   parameter int MAX_CODE_BITS = DefMaxCodeBits,
   parameter int OUT_BURST     = DefOutBurst
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_more_pending,
   output logic       rsp_stream_ended
);

   cmd_type    cmd;
   status_type status;

   lzwvwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .status    (status),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   lzwvwd_dp #(
      .MAX_CODE_BITS (MAX_CODE_BITS),
      .OUT_BURST     (OUT_BURST)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .in_byte      (req_in_byte),
      .status       (status),
      .out_byte     (rsp_out_byte),
      .run_last     (rsp_run_last),
      .more_pending (rsp_more_pending),
      .stream_ended (rsp_stream_ended)
   );

endmodule

@@ rtl/lzwvwd_ram.sv @@
module lzwvwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lzwvwd_ctrl.sv @@
module lzwvwd_ctrl
   import lzwvwd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_mode,
   input  status_type status,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   mode_type  mode;

   assign mode      = mode_type'(req_mode);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_SEND);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (mode)
                  MODE_RESTART: cmd.restart = 1'b1;
                  MODE_CONT: begin
                     if (status.pending) state_in = S_START;
                  end
                  MODE_BYTE: begin
                     if (!status.ended && !status.pending) begin
                        cmd.take_byte = 1'b1;
                        if (status.code_ready) state_in = S_CODE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CODE: begin
            cmd.do_code = 1'b1;
            case (status.kind)
               KIND_SINGLE: state_in = S_START;
               KIND_WALK:   state_in = S_WALK_RD;
               default:     state_in = S_IDLE;
            endcase
         end
         S_WALK_RD: begin
            if (status.walk_more) begin
               cmd.walk_rd = 1'b1;
               state_in    = S_WALK_WR;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_WALK_WR: begin
            cmd.walk_step = 1'b1;
            state_in      = S_WALK_RD;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_START;
         end
         S_START: begin
            cmd.drain_start = 1'b1;
            state_in        = S_RD;
         end
         S_RD: begin
            cmd.buf_rd = 1'b1;
            state_in   = S_LOAD;
         end
         S_LOAD: begin
            cmd.load_rsp = 1'b1;
            state_in     = S_SEND;
         end
         S_SEND: begin
            if (!rsp_stall) begin
               state_in = status.last ? S_IDLE : S_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

@@ rtl/lzwvwd_dp.sv @@
module lzwvwd_dp
   import lzwvwd_pkg::*;
#(
   parameter int MAX_CODE_BITS = DefMaxCodeBits,
   parameter int OUT_BURST     = DefOutBurst
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic [7:0] in_byte,
   output status_type status,
   output logic [7:0] out_byte,
   output logic       run_last,
   output logic       more_pending,
   output logic       stream_ended
);

   localparam int AW    = MAX_CODE_BITS;
   localparam int PW    = AW + 1;
   localparam int DEPTH = 1 << AW;
   localparam int RW    = MAX_CODE_BITS + 8;
   localparam int HW    = $clog2(RW + 1);
   localparam int WW    = $clog2(MAX_CODE_BITS + 1);
   localparam int CW    = $clog2(OUT_BURST + 1);
   localparam int TW    = AW + 8;
   localparam logic [PW-1:0] DepthP  = PW'(DEPTH);
   localparam logic [PW-1:0] FirstP  = PW'(FirstSlot);
   localparam logic [PW-1:0] Limit0  = PW'(1 << MinCodeBits);
   localparam logic [PW-1:0] BurstP  = PW'(OUT_BURST);
   localparam logic [WW-1:0] Width0  = WW'(MinCodeBits);
   localparam logic [WW-1:0] WidthMx = WW'(MAX_CODE_BITS);
   localparam logic [AW-1:0] ClearC  = AW'(ClearCode);
   localparam logic [AW-1:0] EndC    = AW'(EndCode);
   localparam logic [AW-1:0] FirstC  = AW'(FirstSlot);

   logic [RW-1:0] res_ff, res_in;
   logic [HW-1:0] held_ff, held_in;
   logic [WW-1:0] width_ff, width_in;
   logic [PW-1:0] ns_ff, ns_in;
   logic [PW-1:0] limit_ff, limit_in;
   logic [PW-1:0] hw_ff, hw_in;
   logic [AW-1:0] prior_ff, prior_in;
   logic [7:0]    pfb_ff, pfb_in;
   logic          aclr_ff, aclr_in;
   logic [PW-1:0] prd_ff, prd_in;
   logic          pflag_ff, pflag_in;
   logic          ended_ff, ended_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [AW-1:0] c_ff, c_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic          rdz_ff, rdz_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          more_ff, more_in;
   logic          last_ff, last_in;
   logic [7:0]    obyte_ff, obyte_in;

   logic [RW-1:0] res_app, mask;
   logic [HW-1:0] held_app;
   logic          have_code;
   logic [AW-1:0] c0;
   logic [PW-1:0] pos_dec, ns_eff, nread;
   logic          upd;

   logic          tbl_we;
   logic [TW-1:0] tbl_wd, tbl_rd;
   logic [7:0]    sfx;
   logic [AW-1:0] pfx;
   logic          sb_we;
   logic [AW-1:0] sb_wa;
   logic [7:0]    sb_wd, sb_rd;

   // dictionary: prefix above suffix
   lzwvwd_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_tbl (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (ns_ff[AW-1:0]),
      .wr_data (tbl_wd),
      .rd_en   (cmd.walk_rd),
      .rd_addr (c_ff),
      .rd_data (tbl_rd)
   );

   // decoded string, filled top down
   lzwvwd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_sbuf (
      .clock   (clock),
      .wr_en   (sb_we),
      .wr_addr (sb_wa),
      .wr_data (sb_wd),
      .rd_en   (cmd.buf_rd),
      .rd_addr (prd_ff[AW-1:0]),
      .rd_data (sb_rd)
   );

   // bit unpacking, lsb first
   assign res_app   = res_ff | (RW'(in_byte) << held_ff);
   assign held_app  = held_ff + HW'(8);
   assign mask      = (RW'(1) << width_ff) - RW'(1);
   assign have_code = (held_app >= HW'(width_ff));

   // entries at or above the fill mark still read as zero
   assign sfx = rdz_ff ? 8'd0 : tbl_rd[7:0];
   assign pfx = rdz_ff ? '0 : tbl_rd[TW-1:8];

   assign c0      = ({1'b0, cur_ff} >= FirstP) ? '0 : cur_ff;
   assign pos_dec = pos_ff - PW'(1);
   assign upd     = (ns_ff < limit_ff) && (ns_ff < DepthP);
   assign ns_eff  = upd ? ns_ff + PW'(1) : ns_ff;
   assign nread   = prd_ff + PW'(1);
   assign tbl_we  = cmd.finish && upd;
   assign tbl_wd  = {prior_ff, c_ff[7:0]};

   // status
   always_comb begin
      status.code_ready = have_code;
      status.pending    = pflag_ff && !prd_ff[AW];
      status.ended      = ended_ff;
      status.walk_more  = (c_ff >= FirstC) && (pos_ff > PW'(1));
      status.last       = last_ff;
      if (cur_ff == ClearC || cur_ff == EndC) begin
         status.kind = KIND_SKIP;
      end else if (aclr_ff) begin
         status.kind = KIND_SINGLE;
      end else begin
         status.kind = KIND_WALK;
      end
   end

   // string buffer write port
   always_comb begin
      sb_we = 1'b0;
      sb_wa = pos_dec[AW-1:0];
      sb_wd = c_ff[7:0];
      if (cmd.do_code) begin
         sb_wa = '1;
         if (aclr_ff) begin
            sb_we = (status.kind == KIND_SINGLE);
            sb_wd = c0[7:0];
         end else begin
            sb_we = (status.kind == KIND_WALK) && ({1'b0, cur_ff} >= ns_ff);
            sb_wd = pfb_ff;
         end
      end else if (cmd.walk_step) begin
         sb_we = 1'b1;
         sb_wd = sfx;
      end else if (cmd.finish) begin
         sb_we = 1'b1;
      end
   end

   // datapath next values
   always_comb begin
      res_in   = res_ff;
      held_in  = held_ff;
      width_in = width_ff;
      ns_in    = ns_ff;
      limit_in = limit_ff;
      hw_in    = hw_ff;
      prior_in = prior_ff;
      pfb_in   = pfb_ff;
      aclr_in  = aclr_ff;
      prd_in   = prd_ff;
      pflag_in = pflag_ff;
      ended_in = ended_ff;
      cur_in   = cur_ff;
      c_in     = c_ff;
      pos_in   = pos_ff;
      rdz_in   = rdz_ff;
      cnt_in   = cnt_ff;
      more_in  = more_ff;
      last_in  = last_ff;
      obyte_in = obyte_ff;

      if (cmd.restart) begin
         res_in   = '0;
         held_in  = '0;
         width_in = Width0;
         ns_in    = FirstP;
         limit_in = Limit0;
         hw_in    = FirstP;
         prior_in = '0;
         pfb_in   = '0;
         aclr_in  = 1'b0;
         prd_in   = '0;
         pflag_in = 1'b0;
         ended_in = 1'b0;
      end

      if (cmd.take_byte) begin
         if (have_code) begin
            cur_in  = AW'(res_app & mask);
            res_in  = res_app >> width_ff;
            held_in = held_app - HW'(width_ff);
         end else begin
            res_in  = res_app;
            held_in = held_app;
         end
      end

      // first look at a code
      if (cmd.do_code) begin
         if (aclr_ff) begin
            if (cur_ff == EndC) begin
               ended_in = 1'b1;
            end else if (cur_ff != ClearC) begin
               aclr_in  = 1'b0;
               prior_in = c0;
               pfb_in   = c0[7:0];
               prd_in   = DepthP - PW'(1);
               pflag_in = 1'b1;
            end
         end else if (cur_ff == ClearC) begin
            ns_in    = FirstP;
            limit_in = Limit0;
            width_in = Width0;
            aclr_in  = 1'b1;
         end else if (cur_ff == EndC) begin
            ended_in = 1'b1;
         end else if ({1'b0, cur_ff} >= ns_ff) begin
            c_in   = prior_ff;
            pos_in = DepthP - PW'(1);
         end else begin
            c_in   = cur_ff;
            pos_in = DepthP;
         end
      end

      // chain walk
      if (cmd.walk_rd) begin
         rdz_in = ({1'b0, c_ff} >= hw_ff);
      end
      if (cmd.walk_step) begin
         pos_in = pos_dec;
         c_in   = pfx;
      end

      // last byte of the string, dictionary update, width growth
      if (cmd.finish) begin
         pos_in   = pos_dec;
         prd_in   = pos_dec;
         pflag_in = 1'b1;
         if (upd) begin
            pfb_in   = c_ff[7:0];
            prior_in = cur_ff;
            ns_in    = ns_eff;
            if (ns_eff > hw_ff) hw_in = ns_eff;
         end
         if (ns_eff >= limit_ff && width_ff < WidthMx) begin
            limit_in = limit_ff << 1;
            width_in = width_ff + WW'(1);
         end
      end

      // output burst
      if (cmd.drain_start) begin
         cnt_in  = '0;
         more_in = (DepthP - prd_ff) > BurstP;
      end
      if (cmd.load_rsp) begin
         obyte_in = sb_rd;
         prd_in   = nread;
         cnt_in   = cnt_ff + CW'(1);
         last_in  = (cnt_ff + CW'(1) == CW'(OUT_BURST)) || (nread == DepthP);
      end
   end

   // control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff   <= '0;
         held_ff  <= '0;
         width_ff <= Width0;
         ns_ff    <= FirstP;
         limit_ff <= Limit0;
         hw_ff    <= FirstP;
         prior_ff <= '0;
         pfb_ff   <= '0;
         aclr_ff  <= 1'b0;
         prd_ff   <= '0;
         pflag_ff <= 1'b0;
         ended_ff <= 1'b0;
      end else begin
         res_ff   <= res_in;
         held_ff  <= held_in;
         width_ff <= width_in;
         ns_ff    <= ns_in;
         limit_ff <= limit_in;
         hw_ff    <= hw_in;
         prior_ff <= prior_in;
         pfb_ff   <= pfb_in;
         aclr_ff  <= aclr_in;
         prd_ff   <= prd_in;
         pflag_ff <= pflag_in;
         ended_ff <= ended_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      c_ff     <= c_in;
      pos_ff   <= pos_in;
      rdz_ff   <= rdz_in;
      cnt_ff   <= cnt_in;
      more_ff  <= more_in;
      last_ff  <= last_in;
      obyte_ff <= obyte_in;
   end

   assign out_byte     = obyte_ff;
   assign run_last     = last_ff;
   assign more_pending = more_ff;
   assign stream_ended = ended_ff;

endmodule

@@ test/testbench.sv @@
module testbench
   import lzwvwd_pkg::*;
;

   localparam int TableDepth = 1 << DefMaxCodeBits;
   localparam int MaxWidth   = DefMaxCodeBits;
   localparam int CycleLimit = 2000000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_mode = MODE_NONE;
   logic [7:0] req_in_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_more_pending;
   logic       rsp_stream_ended;

   lzw_variable_width_decoder dut (.*);

   always #6 clock = ~clock;

   // one decoded byte as it should leave the block
   typedef struct {
      logic [7:0] out_byte;
      logic       run_last;
      logic       more_pending;
      logic       stream_ended;
   } decoded_word_type;

   decoded_word_type expected_words[$];
   int  failures = 0;
   int  cycle_count = 0;
   bit  hold_long = 1'b0;
   bit  stall_quiet = 1'b0;

   // decoder state mirror
   logic [11:0] prefix_mem[TableDepth];
   logic [7:0]  suffix_mem[TableDepth];
   logic [7:0]  string_mem[TableDepth];
   logic [31:0] reservoir;
   int unsigned held_bits, code_bits, next_slot, slot_limit;
   int unsigned prior_code, read_ptr, end_ptr;
   logic [7:0]  prior_first;
   bit          after_clear, stream_done;

   // encoder state used to build well-formed streams
   logic [31:0] pack_bits;
   int unsigned pack_count, enc_width, enc_next;

   function automatic void clear_decoder();
      for (int i = 0; i < TableDepth; i++) begin
         prefix_mem[i] = '0;
         suffix_mem[i] = '0;
         string_mem[i] = '0;
      end
      reservoir = 0; held_bits = 0; code_bits = MinCodeBits;
      next_slot = FirstSlot; slot_limit = 1 << MinCodeBits;
      prior_code = 0; prior_first = '0; after_clear = 0;
      read_ptr = 0; end_ptr = 0; stream_done = 0;
   endfunction

   function automatic void queue_pending();
      decoded_word_type w;
      int n;
      n = 0;
      while (n < DefOutBurst && read_ptr < end_ptr) begin
         w.out_byte = string_mem[read_ptr % TableDepth];
         read_ptr++;
         n++;
         w.run_last = (n == DefOutBurst) || (read_ptr >= end_ptr);
         w.more_pending = 1'b0;
         w.stream_ended = stream_done;
         expected_words.push_back(w);
      end
      // more_pending is known only once the burst is done
      for (int k = 0; k < n; k++)
         expected_words[expected_words.size() - 1 - k].more_pending = read_ptr < end_ptr;
   endfunction

   function automatic void decode_code(int unsigned cur);
      int unsigned pos, c;
      pos = TableDepth;
      if (after_clear) begin
         if (cur == ClearCode) return;
         if (cur == EndCode) begin
            stream_done = 1;
            return;
         end
         if (cur >= FirstSlot) cur = 0;
         after_clear = 0;
         prior_code = cur;
         prior_first = cur[7:0];
         string_mem[TableDepth-1] = cur[7:0];
         read_ptr = TableDepth - 1;
         end_ptr = TableDepth;
         return;
      end
      if (cur == ClearCode) begin
         next_slot = FirstSlot; slot_limit = 1 << MinCodeBits;
         code_bits = MinCodeBits; after_clear = 1;
         return;
      end
      if (cur == EndCode) begin
         stream_done = 1;
         return;
      end
      c = cur % TableDepth;
      // code not yet in the dictionary: prior string plus its first byte
      if (cur >= next_slot) begin
         c = prior_code % TableDepth;
         pos--;
         string_mem[pos] = prior_first;
      end
      while (c >= FirstSlot && pos > 1) begin
         pos--;
         string_mem[pos] = suffix_mem[c];
         c = 32'(prefix_mem[c]);
      end
      pos--;
      string_mem[pos] = c[7:0];
      if (next_slot < slot_limit && next_slot < TableDepth) begin
         suffix_mem[next_slot] = c[7:0];
         prefix_mem[next_slot] = prior_code[11:0];
         prior_first = c[7:0];
         prior_code = cur;
         next_slot++;
      end
      if (next_slot >= slot_limit && code_bits < MaxWidth) begin
         slot_limit = slot_limit << 1;
         code_bits++;
      end
      read_ptr = pos;
      end_ptr = TableDepth;
   endfunction

   function automatic void predict_word(logic [1:0] mode, logic [7:0] in_byte);
      int unsigned code;
      case (mode)
         MODE_RESTART: clear_decoder();
         MODE_CONT: queue_pending();
         MODE_BYTE: begin
            if (!stream_done && read_ptr >= end_ptr) begin
               reservoir = reservoir | (32'(in_byte) << held_bits);
               held_bits += 8;
               if (held_bits >= code_bits) begin
                  code = reservoir & ((1 << code_bits) - 1);
                  reservoir = reservoir >> code_bits;
                  held_bits -= code_bits;
                  decode_code(code);
                  queue_pending();
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_word(logic [1:0] mode, logic [7:0] in_byte);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if (stall_quiet) gap = 0;
      // the request side goes idle only when a gap follows
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_in_byte <= in_byte;
      do @(posedge clock); while (req_stall);
      predict_word(mode, in_byte);
      @(negedge clock);
   endtask

   // any pending output is drained by continue words
   task automatic flush_pending();
      while (read_ptr < end_ptr) send_word(MODE_CONT, 8'($urandom));
   endtask

   task automatic wait_idle();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (expected_words.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (20) @(negedge clock);
   endtask

   // pack one code into bytes, lsb first
   task automatic put_code(int unsigned code, int unsigned width);
      pack_bits = pack_bits | (code << pack_count);
      pack_count += width;
      while (pack_count >= 8) begin
         flush_pending();
         send_word(MODE_BYTE, pack_bits[7:0]);
         pack_bits = pack_bits >> 8;
         pack_count -= 8;
      end
   endtask

   task automatic finish_packing();
      if (pack_count > 0) begin
         flush_pending();
         send_word(MODE_BYTE, pack_bits[7:0]);
      end
      pack_bits = 0; pack_count = 0;
   endtask

   task automatic start_stream();
      send_word(MODE_RESTART, 8'($urandom));
      pack_bits = 0; pack_count = 0; enc_width = MinCodeBits; enc_next = FirstSlot;
   endtask

   // track the encoder's view of the code width as entries are added
   task automatic put_tracked(int unsigned code, bit first);
      put_code(code, enc_width);
      if (!first && enc_next < TableDepth) begin
         enc_next++;
         if (enc_next >= (1 << enc_width) && enc_width < MaxWidth) enc_width++;
      end
   endtask

   task automatic test_directed();
      start_stream();
      put_code(ClearCode, enc_width);
      put_code(ClearCode, enc_width);
      put_tracked(32'h00, 1'b1);
      put_tracked(32'hff, 1'b0);
      put_tracked(FirstSlot, 1'b0);
      put_tracked(enc_next, 1'b0);
      put_tracked(enc_next + 5, 1'b0);
      put_tracked(32'h5a, 1'b0);
      put_code(EndCode, enc_width);
      finish_packing();
      send_word(MODE_BYTE, 8'hff);
      send_word(MODE_NONE, 8'ha5);
      send_word(MODE_CONT, 8'h00);
      // stream that opens with no clear, first code above the first slot
      start_stream();
      put_tracked(300, 1'b0);
      put_tracked(32'h41, 1'b0);
      put_code(ClearCode, enc_width);
      put_code(FirstSlot + 3, enc_width);
      finish_packing();
      flush_pending();
      wait_idle();
   endtask

   // long strings give bursts over the output limit
   task automatic test_long_strings();
      int unsigned code;
      start_stream();
      put_code(ClearCode, enc_width);
      put_tracked(32'h61, 1'b1);
      code = 32'h61;
      for (int i = 0; i < 90; i++) begin
         code = enc_next;
         put_tracked(code, 1'b0);
      end
      finish_packing();
      flush_pending();
      wait_idle();
   endtask

   // receiver holds off while the sender keeps going
   task automatic test_backpressure();
      hold_long = 1'b1;
      stall_quiet = 1'b1;
      start_stream();
      put_code(ClearCode, enc_width);
      put_tracked($urandom_range(0, 255), 1'b1);
      for (int i = 0; i < 12; i++) begin
         put_tracked($urandom_range(0, 255), 1'b0);
         send_word(MODE_BYTE, 8'($urandom));
      end
      finish_packing();
      flush_pending();
      stall_quiet = 1'b0;
      wait_idle();
   endtask

   task automatic test_random();
      int sent;
      sent = 0;
      while (sent < 220) begin
         if ($urandom_range(0, 4) == 0) begin
            // noise of any mode and byte
            send_word(2'($urandom_range(0, 3)), 8'($urandom));
            sent++;
         end else begin
            start_stream();
            if ($urandom_range(0, 3) != 0) put_code(ClearCode, enc_width);
            put_tracked($urandom_range(0, 255), 1'b1);
            repeat ($urandom_range(3, 40)) begin
               case ($urandom_range(0, 5))
                  0: put_tracked(enc_next, 1'b0);
                  1, 2: put_tracked($urandom_range(FirstSlot, enc_next - 1), 1'b0);
                  3: put_tracked($urandom_range(0, (1 << enc_width) - 1), 1'b0);
                  default: put_tracked($urandom_range(0, 255), 1'b0);
               endcase
               sent += 2;
            end
            if ($urandom_range(0, 1) == 0) put_code(EndCode, enc_width);
            finish_packing();
            if ($urandom_range(0, 2) != 0) flush_pending();
         end
      end
      flush_pending();
      wait_idle();
   endtask

   // receiver stall pattern
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            hold_long = 1'b0;
         end
         n = $urandom_range(0, 9);
         rsp_stall <= (n < 3);
         if (n == 0) repeat ($urandom_range(5, 25)) @(negedge clock);
      end
   end

   // compare each word leaving the block
   always @(posedge clock) begin
      decoded_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word out_byte %0h", rsp_out_byte);
            failures++;
         end else begin
            w = expected_words.pop_front();
            if (rsp_out_byte !== w.out_byte) begin
               $error("out_byte exp %0h got %0h", w.out_byte, rsp_out_byte);
               failures++;
            end
            if (rsp_run_last !== w.run_last) begin
               $error("run_last exp %0b got %0b", w.run_last, rsp_run_last);
               failures++;
            end
            if (rsp_more_pending !== w.more_pending) begin
               $error("more_pending exp %0b got %0b", w.more_pending, rsp_more_pending);
               failures++;
            end
            if (rsp_stream_ended !== w.stream_ended) begin
               $error("stream_ended exp %0b got %0b", w.stream_ended, rsp_stream_ended);
               failures++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      clear_decoder();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_long_strings();
      test_backpressure();
      test_random();
      if (expected_words.size() != 0) begin
         $error("%0d words never arrived", expected_words.size());
         failures++;
      end
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ lzw_variable_width_decoder.f @@
rtl/lzwvwd_pkg.sv
rtl/lzwvwd_ram.sv
rtl/lzwvwd_ctrl.sv
rtl/lzwvwd_dp.sv
rtl/lzw_variable_width_decoder.sv
test/testbench.sv
